// File: rtl/core/tlm_pkg.sv
// Shared types and constants of the transient latency monitor.
`timescale 1ns / 1ps

package tlm_pkg;

	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int P95_NUM = 95;
	localparam int P95_DEN = 100;
	localparam int P95_RECIP = 671089;
	localparam int P95_SHIFT = 26;

	localparam logic [15:0] ONSET_THR_RST = 16'd2048;
	localparam logic [15:0] LEVEL_THR_RST = 16'd2048;
	localparam logic [31:0] HOP_TIME_RST = 32'd8000;
	localparam logic [31:0] HOLDOFF_RST = 32'd200000;

	localparam logic [1:0] REG_ONSET_THR = 2'd0;
	localparam logic [1:0] REG_LEVEL_THR = 2'd1;
	localparam logic [1:0] REG_HOP_TIME = 2'd2;
	localparam logic [1:0] REG_HOLDOFF = 2'd3;

	localparam logic FUNC_FRAME = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F_CHECK,
		ST_F_DIFF,
		ST_F_COMMIT,
		ST_Q_P95_LD,
		ST_Q_CAND,
		ST_Q_LOAD,
		ST_Q_SCAN,
		ST_Q_EVAL,
		ST_Q_MEAN_LD,
		ST_Q_MEAN_DIV,
		ST_DONE
	} tlm_state_t;

endpackage

// File: rtl/core/tlm_ram.sv
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps

module tlm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/transient_latency_monitor_unit.sv
// Transient latency monitor: detects level crossings and reports latency statistics.
//
// Requests arrive on the s_ stream channel; s_tuser selects an audio frame (0) or a
// statistics query (1). Each request produces exactly one response on the m_ stream
// channel. A frame passes through the check, difference and commit states before its
// response register is loaded in the done state. A query at the default depth of 64
// is paced by the rank count, which reads every stored sample once per candidate
// through the single read port of the history RAM, and by the bit-serial divider used
// for the mean, which takes one step per sum bit. The p95 rank comes from a multiply
// by a constant reciprocal. An empty query goes straight from idle to the done state.
// s_tready is high only while the sequencer is idle. The response waits in an output
// register while m_tready is low; the sequencer holds its finished response until that
// register is free, so a stalled receiver eventually stalls the request side.
// After reset the thresholds and times take their default values, the history is empty,
// and the counters and cooldown are zero. Registers are written through the APB port
// while no request is in progress; the user must ensure this, the block does not.
`timescale 1ns / 1ps

module transient_latency_monitor_unit #(
	parameter int HISTORY_DEPTH = tlm_pkg::HISTORY_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// onset level, peak level, capture stamp, publish stamp, clear flag, zero pad
	input  logic [167:0] s_tdata,
	// func
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// detected, latency, transients, samples, median_latency, p95_latency,
	// max_latency, mean_latency
	output logic [199:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = 32 + CNT_W;
	localparam int DV_W = (CNT_W > 7) ? CNT_W : 7;
	localparam int DC_W = $clog2(SUM_W + 1);

	tlm_pkg::tlm_state_t state_q, state_d;

	logic [15:0] onset_thr_q, level_thr_q;
	logic [31:0] hop_q, holdoff_q;

	logic        func_q, clr_q;
	logic [15:0] onset_q, peak_q;
	logic [63:0] cap_q, pub_q;

	logic [15:0] last_onset_q, last_peak_q;
	logic [63:0] holdoff_end_q;
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] filled_q;
	logic [31:0] total_q;

	logic        win_q, cross_q, rec_q;
	logic [63:0] hs_q;
	logic [31:0] lat_q;

	logic [CNT_W-1:0] i_q, j_q, less_q, eq_q;
	logic [31:0] cand_q, med_q, p95_q, max_q;
	logic [SUM_W-1:0] sum_q, div_q;
	logic [DV_W:0]   rem_q;
	logic [DV_W-1:0] divisor_q;
	logic [DC_W-1:0] dcnt_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_raddr;
	logic [31:0]      ram_rdata;

	logic             cfg_wr, in_acc, out_free, has_data;
	logic [CNT_W-1:0] n_last, med_rank, p95_rank;
	logic [CNT_W:0]   rank_hi;
	logic [CNT_W+6:0] p95_num;
	logic [CNT_W+26:0] p95_prod;
	logic [DV_W:0]    trial;
	logic             trial_ok;
	logic [64:0]      diff;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign has_data = (filled_q != '0);

	assign n_last = filled_q - CNT_W'(1);
	assign med_rank = filled_q >> 1;
	assign p95_rank = div_q[CNT_W-1:0];
	assign rank_hi = {1'b0, less_q} + {1'b0, eq_q};
	assign p95_num = (CNT_W + 7)'(filled_q) * 7'(tlm_pkg::P95_NUM);
	assign p95_prod = (CNT_W + 27)'(p95_num) * (CNT_W + 27)'(tlm_pkg::P95_RECIP);
	assign trial = {rem_q[DV_W-1:0], div_q[SUM_W-1]};
	assign trial_ok = (trial >= {1'b0, divisor_q});
	assign diff = {1'b0, pub_q} - {1'b0, hs_q};

	function automatic logic rank_hit(input logic [CNT_W-1:0] r, input logic [CNT_W-1:0] lo,
					  input logic [CNT_W:0] hi);
		rank_hit = ({1'b0, lo} <= {1'b0, r}) && ({1'b0, r} < hi);
	endfunction

	always_comb begin
		unique case (paddr[3:2])
			tlm_pkg::REG_ONSET_THR: prdata = {16'd0, onset_thr_q};
			tlm_pkg::REG_LEVEL_THR: prdata = {16'd0, level_thr_q};
			tlm_pkg::REG_HOP_TIME:  prdata = hop_q;
			tlm_pkg::REG_HOLDOFF:   prdata = holdoff_q;
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			onset_thr_q <= tlm_pkg::ONSET_THR_RST;
			level_thr_q <= tlm_pkg::LEVEL_THR_RST;
			hop_q <= tlm_pkg::HOP_TIME_RST;
			holdoff_q <= tlm_pkg::HOLDOFF_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tlm_pkg::REG_ONSET_THR: onset_thr_q <= pwdata[15:0];
				tlm_pkg::REG_LEVEL_THR: level_thr_q <= pwdata[15:0];
				tlm_pkg::REG_HOP_TIME:  hop_q <= pwdata;
				tlm_pkg::REG_HOLDOFF:   holdoff_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlm_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == tlm_pkg::FUNC_FRAME) begin
						state_d = tlm_pkg::ST_F_CHECK;
					end else if (has_data) begin
						state_d = tlm_pkg::ST_Q_P95_LD;
					end else begin
						state_d = tlm_pkg::ST_DONE;
					end
				end
			end
			tlm_pkg::ST_F_CHECK:   state_d = tlm_pkg::ST_F_DIFF;
			tlm_pkg::ST_F_DIFF:    state_d = tlm_pkg::ST_F_COMMIT;
			tlm_pkg::ST_F_COMMIT:  state_d = tlm_pkg::ST_DONE;
			tlm_pkg::ST_Q_P95_LD:  state_d = tlm_pkg::ST_Q_CAND;
			tlm_pkg::ST_Q_CAND:    state_d = tlm_pkg::ST_Q_LOAD;
			tlm_pkg::ST_Q_LOAD:    state_d = tlm_pkg::ST_Q_SCAN;
			tlm_pkg::ST_Q_SCAN: begin
				if (j_q == n_last) begin
					state_d = tlm_pkg::ST_Q_EVAL;
				end
			end
			tlm_pkg::ST_Q_EVAL: begin
				if (i_q == n_last) begin
					state_d = tlm_pkg::ST_Q_MEAN_LD;
				end else begin
					state_d = tlm_pkg::ST_Q_CAND;
				end
			end
			tlm_pkg::ST_Q_MEAN_LD: state_d = tlm_pkg::ST_Q_MEAN_DIV;
			tlm_pkg::ST_Q_MEAN_DIV: begin
				if (dcnt_q == DC_W'(SUM_W - 1)) begin
					state_d = tlm_pkg::ST_DONE;
				end
			end
			tlm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = tlm_pkg::ST_IDLE;
				end
			end
			default: state_d = tlm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == tlm_pkg::ST_IDLE);
		ram_we = (state_q == tlm_pkg::ST_F_COMMIT) && win_q && cross_q && rec_q;
		unique case (state_q)
			tlm_pkg::ST_Q_CAND: ram_raddr = i_q[IDX_W-1:0];
			tlm_pkg::ST_Q_SCAN: ram_raddr = IDX_W'(j_q + CNT_W'(1));
			default:            ram_raddr = '0;
		endcase
	end

	tlm_ram #(
		.WIDTH(32),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk(clk),
		.we(ram_we),
		.waddr(slot_q),
		.wdata(lat_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlm_pkg::ST_IDLE;
			last_onset_q <= '0;
			last_peak_q <= '0;
			holdoff_end_q <= '0;
			slot_q <= '0;
			filled_q <= '0;
			total_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tlm_pkg::ST_F_COMMIT) begin
				last_onset_q <= onset_q;
				last_peak_q <= peak_q;
				if (win_q && cross_q) begin
					holdoff_end_q <= pub_q + {32'd0, holdoff_q};
					if (rec_q) begin
						slot_q <= (slot_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0
							: slot_q + IDX_W'(1);
						if (filled_q != CNT_W'(HISTORY_DEPTH)) begin
							filled_q <= filled_q + CNT_W'(1);
						end
						total_q <= total_q + 32'd1;
					end
				end
			end
			if (state_q == tlm_pkg::ST_DONE && out_free) begin
				m_tvalid <= 1'b1;
				if (func_q == tlm_pkg::FUNC_QUERY && has_data && clr_q) begin
					total_q <= '0;
				end
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= s_tuser;
			onset_q <= s_tdata[15:0];
			peak_q <= s_tdata[31:16];
			cap_q <= s_tdata[95:32];
			pub_q <= s_tdata[159:96];
			clr_q <= s_tdata[160];
			sum_q <= '0;
			i_q <= '0;
		end
		unique case (state_q)
			tlm_pkg::ST_F_CHECK: begin
				win_q <= (pub_q >= holdoff_end_q);
				cross_q <= ((onset_q >= onset_thr_q) && (last_onset_q < onset_thr_q))
					|| ((peak_q >= level_thr_q) && (last_peak_q < level_thr_q));
				hs_q <= cap_q - {32'd0, hop_q};
			end
			tlm_pkg::ST_F_DIFF: begin
				rec_q <= !diff[64] && (diff[63:0] != '0);
				lat_q <= (diff[63:32] != '0) ? '1 : diff[31:0];
			end
			tlm_pkg::ST_Q_P95_LD: begin
				div_q <= SUM_W'(p95_prod >> tlm_pkg::P95_SHIFT);
			end
			tlm_pkg::ST_Q_MEAN_LD: begin
				div_q <= sum_q;
				divisor_q <= DV_W'(filled_q);
				rem_q <= '0;
				dcnt_q <= '0;
			end
			tlm_pkg::ST_Q_MEAN_DIV: begin
				rem_q <= trial_ok ? (trial - {1'b0, divisor_q}) : trial;
				div_q <= {div_q[SUM_W-2:0], trial_ok};
				dcnt_q <= dcnt_q + DC_W'(1);
			end
			tlm_pkg::ST_Q_LOAD: begin
				cand_q <= ram_rdata;
				sum_q <= sum_q + SUM_W'(ram_rdata);
				j_q <= '0;
				less_q <= '0;
				eq_q <= '0;
			end
			tlm_pkg::ST_Q_SCAN: begin
				if (ram_rdata < cand_q) begin
					less_q <= less_q + CNT_W'(1);
				end
				if (ram_rdata == cand_q) begin
					eq_q <= eq_q + CNT_W'(1);
				end
				j_q <= j_q + CNT_W'(1);
			end
			tlm_pkg::ST_Q_EVAL: begin
				if (rank_hit(med_rank, less_q, rank_hi)) begin
					med_q <= cand_q;
				end
				if (rank_hit(p95_rank, less_q, rank_hi)) begin
					p95_q <= cand_q;
				end
				if (rank_hit(n_last, less_q, rank_hi)) begin
					max_q <= cand_q;
				end
				i_q <= i_q + CNT_W'(1);
			end
			default: ;
		endcase
		if (state_q == tlm_pkg::ST_DONE && out_free) begin
			if (func_q == tlm_pkg::FUNC_FRAME) begin
				m_tdata <= {128'd0, 7'(filled_q), total_q,
					(win_q && cross_q && rec_q) ? lat_q : 32'd0,
					win_q && cross_q && rec_q};
			end else if (has_data) begin
				m_tdata <= {div_q[31:0], max_q, p95_q, med_q, 7'(filled_q), total_q,
					33'd0};
			end else begin
				m_tdata <= {128'd0, 7'(filled_q), total_q, 33'd0};
			end
		end
	end

`ifndef SYNTHESIS
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history fill count beyond depth");

	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(filled_q != CNT_W'(HISTORY_DEPTH)) |-> (CNT_W'(slot_q) == filled_q))
		else $error("write slot out of step with fill count before wrap");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (total_q == $past(total_q) + 32'd1))
		else $error("history write without transient count step");
`endif

endmodule

// File: test/transient_latency_monitor_unit_tb.sv
// Self-checking testbench of the transient latency monitor: directed and random requests.
`timescale 1ns / 1ps

module transient_latency_monitor_unit_tb;

	typedef struct packed {
		logic        func;
		logic [15:0] onset;
		logic [15:0] peak;
		logic [63:0] cap;
		logic [63:0] pub;
		logic        clr;
	} req_t;

	typedef struct packed {
		logic        det;
		logic [31:0] lat;
		logic [31:0] trans;
		logic [6:0]  samp;
		logic [31:0] med;
		logic [31:0] p95;
		logic [31:0] mx;
		logic [31:0] mean;
	} rsp_t;

	typedef struct packed {
		req_t req;
		logic typed;
		rsp_t rsp;
	} row_t;

	localparam int DEPTH = tlm_pkg::HISTORY_DEPTH_DEF;
	localparam int WD_LIMIT = 60000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [167:0] s_tdata = '0;
	logic         s_tuser = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [199:0] m_tdata;
	logic         psel = 0;
	logic         penable = 0;
	logic         pwrite = 0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	transient_latency_monitor_unit u_dut (.*);

	always #4 clk = ~clk;

	// Model state of the monitor.
	logic [15:0] onset_thr, level_thr;
	logic [31:0] hop_us, cooldown_us;
	logic [15:0] prev_onset, prev_peak;
	logic [63:0] cooldown_end;
	logic [31:0] lat_ring [DEPTH];
	int          ring_wr, ring_fill;
	logic [31:0] transient_cnt;

	rsp_t expected_rsp [$];
	row_t dir_tab [$];
	int   errors = 0, n_frames = 0, n_queries = 0, n_detect = 0, n_rsp = 0;
	int   idle_cycles = 0;
	logic [63:0] tnow;

	function automatic rsp_t monitor_step(req_t r);
		rsp_t        o;
		logic [63:0] hop_origin, d;
		logic [31:0] srt [DEPTH];
		logic [31:0] x;
		logic [63:0] sum;
		int          i, j;
		o = '0;
		if (r.func == tlm_pkg::FUNC_FRAME) begin
			if (r.pub >= cooldown_end) begin
				if ((r.onset >= onset_thr && prev_onset < onset_thr) ||
				    (r.peak >= level_thr && prev_peak < level_thr)) begin
					hop_origin = r.cap - {32'd0, hop_us};
					if (r.pub > hop_origin) begin
						d = r.pub - hop_origin;
						o.lat = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
						o.det = 1'b1;
						lat_ring[ring_wr] = o.lat;
						ring_wr = (ring_wr + 1) % DEPTH;
						if (ring_fill < DEPTH) ring_fill++;
						transient_cnt = transient_cnt + 32'd1;
					end
					cooldown_end = r.pub + {32'd0, cooldown_us};
				end
			end
			prev_onset = r.onset;
			prev_peak = r.peak;
			o.trans = transient_cnt;
		end else begin
			o.trans = transient_cnt;
			if (ring_fill > 0) begin
				sum = 0;
				for (i = 0; i < ring_fill; i++) srt[i] = lat_ring[i];
				for (i = 1; i < ring_fill; i++) begin
					x = srt[i];
					j = i;
					while (j > 0 && srt[j - 1] > x) begin
						srt[j] = srt[j - 1];
						j--;
					end
					srt[j] = x;
				end
				for (i = 0; i < ring_fill; i++) sum += srt[i];
				o.med = srt[ring_fill / 2];
				o.p95 = srt[(ring_fill * tlm_pkg::P95_NUM) / tlm_pkg::P95_DEN];
				o.mx = srt[ring_fill - 1];
				o.mean = 32'(sum / ring_fill);
				if (r.clr) transient_cnt = 0;
			end
		end
		o.samp = ring_fill[6:0];
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Response checker.
	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[32:1], m_tdata[64:33], m_tdata[71:65],
			       m_tdata[103:72], m_tdata[135:104], m_tdata[167:136], m_tdata[199:168]};
			n_rsp++;
			if (expected_rsp.size() == 0) begin
				report("unexpected response", 1, 0);
			end else begin
				want = expected_rsp.pop_front();
				if (got.det !== want.det) report("detected", got.det, want.det);
				if (got.lat !== want.lat) report("latency", got.lat, want.lat);
				if (got.trans !== want.trans) report("transients", got.trans, want.trans);
				if (got.samp !== want.samp) report("samples", got.samp, want.samp);
				if (got.med !== want.med) report("median_latency", got.med, want.med);
				if (got.p95 !== want.p95) report("p95_latency", got.p95, want.p95);
				if (got.mx !== want.mx) report("max_latency", got.mx, want.mx);
				if (got.mean !== want.mean) report("mean_latency", got.mean, want.mean);
			end
		end
	end

	// Receiver stalls in four random modes, from always ready to rarely ready.
	int stall_mode = 0, stall_cnt = 0;
	always @(posedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_cnt <= $urandom_range(10, 80);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 0);
			2: m_tready <= ($urandom_range(0, 9) != 0);
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", WD_LIMIT);
				$display("[transient_latency_monitor_unit] ERROR");
				$finish;
			end
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		wait (expected_rsp.size() == 0);
		repeat (10) @(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			tlm_pkg::REG_ONSET_THR: onset_thr = val[15:0];
			tlm_pkg::REG_LEVEL_THR: level_thr = val[15:0];
			tlm_pkg::REG_HOP_TIME: hop_us = val;
			default: cooldown_us = val;
		endcase
	endtask

	task automatic cfg_all(logic [15:0] ot, logic [15:0] lt, logic [31:0] hp, logic [31:0] cd);
		cfg_write(tlm_pkg::REG_ONSET_THR, {16'd0, ot});
		cfg_write(tlm_pkg::REG_LEVEL_THR, {16'd0, lt});
		cfg_write(tlm_pkg::REG_HOP_TIME, hp);
		cfg_write(tlm_pkg::REG_HOLDOFF, cd);
	endtask

	int burst_left = 0;
	task automatic send_request(req_t r, logic typed, rsp_t typed_rsp);
		int   gap;
		rsp_t p;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= r.func;
		s_tdata <= {7'd0, r.clr, r.pub, r.cap, r.peak, r.onset};
		do @(posedge clk); while (!s_tready);
		p = monitor_step(r);
		expected_rsp.push_back(typed ? typed_rsp : p);
		if (r.func == tlm_pkg::FUNC_FRAME) n_frames++;
		else n_queries++;
		if (p.det) n_detect++;
	endtask

	function automatic row_t mk(logic f, logic [15:0] o, logic [15:0] pk, logic [63:0] c,
	                            logic [63:0] pb, logic cl);
		row_t w;
		w = '0;
		w.req = '{f, o, pk, c, pb, cl};
		return w;
	endfunction

	function automatic logic [15:0] below(logic [15:0] thr);
		return (thr == 0) ? 16'd0 : 16'($urandom_range(0, thr - 1));
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   k;
		k = $urandom_range(0, 99);
		r = '0;
		r.clr = 1'($urandom_range(0, 1));
		if (k < 12) begin
			r.func = tlm_pkg::FUNC_QUERY;
			r.cap = {$urandom, $urandom};
			r.pub = {$urandom, $urandom};
			r.onset = 16'($urandom);
			r.peak = 16'($urandom);
		end else if (k < 90) begin
			r.func = tlm_pkg::FUNC_FRAME;
			tnow += ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 300000));
			r.pub = tnow;
			r.cap = tnow - 64'($urandom_range(0, 20000));
			if (prev_onset < onset_thr && prev_peak < level_thr && $urandom_range(0, 2) != 0) begin
				r.onset = $urandom_range(0, 1) ? 16'($urandom_range(onset_thr, 65535))
				                               : below(onset_thr);
				r.peak = $urandom_range(0, 1) ? 16'($urandom_range(level_thr, 65535))
				                              : below(level_thr);
			end else begin
				r.onset = below(onset_thr);
				r.peak = below(level_thr);
			end
		end else begin
			r.func = tlm_pkg::FUNC_FRAME;
			r.onset = 16'($urandom);
			r.peak = 16'($urandom);
			r.cap = {$urandom, $urandom};
			r.pub = {$urandom, $urandom};
			if (r.pub > tnow) tnow = r.pub;
		end
		return r;
	endfunction

	initial begin
		row_t w;
		int   ph, i;
		onset_thr = tlm_pkg::ONSET_THR_RST;
		level_thr = tlm_pkg::LEVEL_THR_RST;
		hop_us = tlm_pkg::HOP_TIME_RST;
		cooldown_us = tlm_pkg::HOLDOFF_RST;
		prev_onset = 0;
		prev_peak = 0;
		cooldown_end = 0;
		ring_wr = 0;
		ring_fill = 0;
		transient_cnt = 0;
		tnow = 64'd5_000_000;

		w = mk(tlm_pkg::FUNC_QUERY, 16'hFFFF, 16'hFFFF, '1, '1, 1'b1);
		w.typed = 1'b1;
		dir_tab.push_back(w);
		w = mk(tlm_pkg::FUNC_FRAME, 16'd4096, 16'd0, 64'd1_000_000, 64'd1_000_500, 1'b0);
		w.typed = 1'b1;
		w.rsp = '{1'b1, 32'd8500, 32'd1, 7'd1, 32'd0, 32'd0, 32'd0, 32'd0};
		dir_tab.push_back(w);
		w = mk(tlm_pkg::FUNC_QUERY, 16'd0, 16'd0, 64'd0, 64'd0, 1'b1);
		w.typed = 1'b1;
		w.rsp = '{1'b0, 32'd0, 32'd1, 7'd1, 32'd8500, 32'd8500, 32'd8500, 32'd8500};
		dir_tab.push_back(w);
		w = mk(tlm_pkg::FUNC_QUERY, 16'd0, 16'd0, 64'd0, 64'd0, 1'b0);
		w.typed = 1'b1;
		w.rsp = '{1'b0, 32'd0, 32'd0, 7'd1, 32'd8500, 32'd8500, 32'd8500, 32'd8500};
		dir_tab.push_back(w);
		// Inside the cooldown, then levels drop, then a crossing whose hop start is too late.
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd0, 16'hFFFF, 64'd1_000_600,
		                     64'd1_000_700, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd0, 16'd0, 64'd1_300_000,
		                     64'd1_300_000, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd0, 16'd2048, 64'd9_000_000,
		                     64'd1_400_000, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd0, 16'd0, 64'd1_450_000,
		                     64'd1_450_000, 1'b0));
		// Saturated latency once the rearmed cooldown is over.
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd2048, 16'd0, 64'd8000,
		                     64'h100_0000_0000, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd0, 16'd0, 64'h200_0000_0000,
		                     64'h200_0000_0000, 1'b0));
		// Hop start wraps below zero; cooldown end wraps past the top.
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'hFFFF, 16'hFFFF, 64'd100,
		                     64'hFFFF_FFFF_FFFF_FFF0, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd0, 16'd0, 64'd0, 64'd10, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'hFFFF, 16'd0, '1, '1, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd0, 16'd0, 64'd0, 64'd500_000, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_FRAME, 16'd0, 16'hFFFF, 64'd600_000,
		                     64'd700_000, 1'b1));
		dir_tab.push_back(mk(tlm_pkg::FUNC_QUERY, 16'd0, 16'd0, 64'd0, 64'd0, 1'b0));
		dir_tab.push_back(mk(tlm_pkg::FUNC_QUERY, 16'hFFFF, 16'hFFFF, '1, '1, 1'b1));

		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_tab[k]) send_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].rsp);

		for (ph = 0; ph < 4; ph++) begin
			s_tvalid <= 0;
			case (ph)
				0: cfg_all(16'd0, 16'd0, 32'd0, 32'd0);
				1: cfg_all(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: cfg_all(16'($urandom), 16'($urandom), $urandom_range(0, 20000),
				           $urandom_range(0, 400000));
				default: cfg_all(tlm_pkg::ONSET_THR_RST, tlm_pkg::LEVEL_THR_RST,
				                 tlm_pkg::HOP_TIME_RST, tlm_pkg::HOLDOFF_RST);
			endcase
			for (i = 0; i < 32; i++) send_request(random_request(), 1'b0, '0);
		end
		s_tvalid <= 0;

		wait (expected_rsp.size() == 0);
		repeat (20) @(posedge clk);
		$display("run covered %0d frames, %0d queries, %0d recorded transients, %0d responses",
		         n_frames, n_queries, n_detect, n_rsp);
		$display("four register settings including both extremes, %0d mismatches", errors);
		if (errors == 0) begin
			$display("[transient_latency_monitor_unit] OK");
		end else begin
			$display("[transient_latency_monitor_unit] ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/tlm_pkg.sv
rtl/core/tlm_ram.sv
rtl/core/transient_latency_monitor_unit.sv
test/transient_latency_monitor_unit_tb.sv
